>>> rtl/core/tlik_pkg.sv
// Shared types, constants and the arctangent table for the two-link arm solver.
package tlik_pkg;

  localparam int REG_W = 14;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int ANGLE_W = 16;

  localparam int A0_W = 30;
  localparam int RAD_W = 60;
  localparam int ROOT_W = 30;
  localparam int RT_W = 62;
  localparam int SQRT_STEPS = 31;

  localparam int PW = 48;
  localparam int CW = 52;
  localparam int ZW = 34;
  localparam int CORDIC_STEPS = 31;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam logic [REG_W-1:0] BASE_HEIGHT_RST = 14'd5312;
  localparam logic [REG_W-1:0] FIRST_LINK_RST = 14'd2560;
  localparam logic [REG_W-1:0] SECOND_LINK_RST = 14'd4960;
  localparam logic [REG_W-1:0] TOOL_OFFSET_RST = 14'd1113;

  typedef enum logic [1:0] {
    REG_BASE_HEIGHT,
    REG_FIRST_LINK,
    REG_SECOND_LINK,
    REG_TOOL_OFFSET
  } reg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] base_height;
    logic [REG_W-1:0] first_link_length;
    logic [REG_W-1:0] second_link_length;
    logic [REG_W-1:0] tool_offset;
  } cfg_t;

  typedef struct packed {
    logic               reach;
    logic signed [31:0] a;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [REG_W-1:0]   r;
    logic [A0_W-1:0]    a0;
  } geom_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 34'sd843314857;
      1: v = 34'sd497837830;
      2: v = 34'sd263043837;
      3: v = 34'sd133525159;
      4: v = 34'sd67021687;
      5: v = 34'sd33543516;
      6: v = 34'sd16775851;
      7: v = 34'sd8388437;
      8: v = 34'sd4194283;
      9: v = 34'sd2097149;
      default: v = $signed(ZW'(64'd1 << (30 - i)));
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/two_link_arm_inverse_kinematics_top.sv
// Throughput: one request per cycle while the skid stage is empty (in_tready low
// otherwise), set by the fully pipelined square root (31 stages) and the two
// parallel 31-stage CORDIC arctangent units.
// A two-entry output register and skid stage decouple the result side.
// Reset (synchronous, rst_n low) clears all valid bits and loads register defaults.
module two_link_arm_inverse_kinematics_top #(
  parameter int ANGLE_FRAC_BITS = tlik_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // target_radius[13:0], target_height[27:14], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // shoulder_angle[15:0], elbow_angle[31:16]
  output logic [0:0]  out_tuser,  // reachable[0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tlik_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t widx;
  logic     ce;

  assign widx       = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_height        <= BASE_HEIGHT_RST;
      cfg_r.first_link_length  <= FIRST_LINK_RST;
      cfg_r.second_link_length <= SECOND_LINK_RST;
      cfg_r.tool_offset        <= TOOL_OFFSET_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (widx)
        REG_BASE_HEIGHT: cfg_r.base_height        <= cfg_pwdata[REG_W-1:0];
        REG_FIRST_LINK:  cfg_r.first_link_length  <= cfg_pwdata[REG_W-1:0];
        REG_SECOND_LINK: cfg_r.second_link_length <= cfg_pwdata[REG_W-1:0];
        REG_TOOL_OFFSET: cfg_r.tool_offset        <= cfg_pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_BASE_HEIGHT: cfg_prdata = {18'd0, cfg_r.base_height};
      REG_FIRST_LINK:  cfg_prdata = {18'd0, cfg_r.first_link_length};
      REG_SECOND_LINK: cfg_prdata = {18'd0, cfg_r.second_link_length};
      REG_TOOL_OFFSET: cfg_prdata = {18'd0, cfg_r.tool_offset};
      default:         cfg_prdata = '0;
    endcase
  end

  logic             fr_valid;
  geom_t            fr_geom;
  logic [RAD_W-1:0] fr_rad;

  tlik_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (in_tvalid && in_tready),
    .in_r      (in_tdata[13:0]),
    .in_h      (in_tdata[27:14]),
    .cfg       (cfg_r),
    .out_valid (fr_valid),
    .out_geom  (fr_geom),
    .out_rad   (fr_rad)
  );

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  geom_t             sb_r [SQRT_STEPS];

  tlik_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (fr_valid),
    .in_rad    (fr_rad),
    .out_valid (sq_valid),
    .out_root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (ce) begin
      sb_r[0] <= fr_geom;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  geom_t              g;
  logic signed [30:0] s_sg;
  assign g    = sb_r[SQRT_STEPS-1];
  assign s_sg = $signed({1'b0, sq_root});

  logic                 m_v_r, n_v_r, w_v_r;
  logic                 m_reach_r, n_reach_r, w_reach_r, m_dypos_r;
  logic signed [PW-1:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  logic signed [PW-1:0] nx_r, ny_r, n_p5_r, n_p6_r;
  logic signed [PW-1:0] w_nx_r, w_ny_r, w_x2_r, w_y2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      n_v_r <= 1'b0;
      w_v_r <= 1'b0;
    end else if (ce) begin
      m_v_r <= sq_valid;
      n_v_r <= m_v_r;
      w_v_r <= n_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_reach_r <= g.reach;
      m_dypos_r <= g.dy > 0;
      p1_r      <= PW'(g.a) * PW'(g.dx);
      p2_r      <= PW'(g.dy) * PW'(s_sg);
      p3_r      <= PW'(g.a) * PW'(g.dy);
      p4_r      <= PW'(g.dx) * PW'(s_sg);
      p5_r      <= PW'($signed({1'b0, g.a0})) * PW'(g.dy);
      p6_r      <= PW'($signed({1'b0, g.a0})) * PW'($signed({1'b0, g.r}));

      n_reach_r <= m_reach_r;
      nx_r      <= m_dypos_r ? p1_r + p2_r : p1_r - p2_r;
      ny_r      <= m_dypos_r ? p3_r - p4_r : p3_r + p4_r;
      n_p5_r    <= p5_r;
      n_p6_r    <= p6_r;

      w_reach_r <= n_reach_r;
      w_nx_r    <= nx_r;
      w_ny_r    <= ny_r;
      w_y2_r    <= (n_p5_r <<< 1) - ny_r;
      w_x2_r    <= (n_p6_r <<< 1) - nx_r;
    end
  end

  logic                      c_valid, c_valid2;
  logic signed [ANGLE_W-1:0] sh_angle, el_angle;
  logic                      rch_r [CORDIC_STEPS + 2];

  tlik_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic_sh (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (w_v_r),
    .in_keep   (w_reach_r),
    .in_y      (w_ny_r),
    .in_x      (w_nx_r),
    .out_valid (c_valid),
    .out_angle (sh_angle)
  );

  tlik_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic_el (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (w_v_r),
    .in_keep   (w_reach_r),
    .in_y      (w_y2_r),
    .in_x      (w_x2_r),
    .out_valid (c_valid2),
    .out_angle (el_angle)
  );

  always_ff @(posedge clk) begin
    if (ce) begin
      rch_r[0] <= w_reach_r;
      for (int k = 1; k < CORDIC_STEPS + 2; k++) begin
        rch_r[k] <= rch_r[k-1];
      end
    end
  end

  logic        res_v;
  logic [32:0] res_d;
  logic        out_v_r, skid_v_r, pop;
  logic [32:0] out_d_r, skid_d_r;

  assign res_v = c_valid && c_valid2;
  assign res_d = {rch_r[CORDIC_STEPS+1], el_angle, sh_angle};
  assign ce    = !skid_v_r;
  assign pop   = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (res_v) begin
      if (!out_v_r || pop) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_d_r <= skid_d_r;
      end
    end else if (res_v) begin
      if (!out_v_r || pop) begin
        out_d_r <= res_d;
      end else begin
        skid_d_r <= res_d;
      end
    end
  end

  assign in_tready  = ce;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r[31:0];
  assign out_tuser  = out_d_r[32];

endmodule

>>> rtl/core/tlik_front.sv
// Front stages: shoulder-frame offsets, squared distances, ring check and radicand product.
module tlik_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            ce,
  input  logic            in_valid,
  input  logic [13:0]     in_r,
  input  logic [13:0]     in_h,
  input  tlik_pkg::cfg_t  cfg,
  output logic            out_valid,
  output tlik_pkg::geom_t out_geom,
  output logic [59:0]     out_rad
);
  import tlik_pkg::*;

  logic               v1_r, v2_r, v3_r, v4_r;
  logic signed [15:0] dx1_r, dy1_r, dx2_r, dy2_r, dx3_r, dy3_r;
  logic [REG_W-1:0]   r1_r, r2_r, r3_r;
  logic [14:0]        sum1_r;
  logic signed [14:0] diff1_r;
  logic [A0_W-1:0]    a0_2_r, outer2_r, inner2_r, a0_3_r;
  logic signed [31:0] ldiff2_r, a3_r;
  logic               reach3_r;
  logic [A0_W-1:0]    f1_3_r, f2_3_r;
  geom_t              geom4_r;
  logic [RAD_W-1:0]   rad4_r;

  logic signed [15:0] dx_nxt, dy_nxt;
  logic signed [31:0] sq_sum;
  logic               reach_nxt;

  assign dx_nxt = $signed({2'b00, in_r}) - $signed({2'b00, cfg.tool_offset});
  assign dy_nxt = $signed({2'b00, in_h}) - $signed({2'b00, cfg.base_height});
  assign sq_sum = 32'(dx1_r) * 32'(dx1_r) + 32'(dy1_r) * 32'(dy1_r);
  assign reach_nxt = (a0_2_r <= outer2_r) && (a0_2_r >= inner2_r) && (a0_2_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dx1_r   <= dx_nxt;
      dy1_r   <= dy_nxt;
      r1_r    <= in_r;
      sum1_r  <= {1'b0, cfg.first_link_length} + {1'b0, cfg.second_link_length};
      diff1_r <= $signed({1'b0, cfg.first_link_length})
                 - $signed({1'b0, cfg.second_link_length});

      a0_2_r   <= A0_W'(sq_sum);
      outer2_r <= A0_W'({15'd0, sum1_r} * {15'd0, sum1_r});
      inner2_r <= A0_W'(32'(diff1_r) * 32'(diff1_r));
      ldiff2_r <= 32'(diff1_r) * $signed({17'd0, sum1_r});
      dx2_r    <= dx1_r;
      dy2_r    <= dy1_r;
      r2_r     <= r1_r;

      reach3_r <= reach_nxt;
      a3_r     <= $signed({2'b00, a0_2_r}) + ldiff2_r;
      f1_3_r   <= reach_nxt ? outer2_r - a0_2_r : '0;
      f2_3_r   <= reach_nxt ? a0_2_r - inner2_r : '0;
      a0_3_r   <= a0_2_r;
      dx3_r    <= dx2_r;
      dy3_r    <= dy2_r;
      r3_r     <= r2_r;

      rad4_r        <= {30'd0, f1_3_r} * {30'd0, f2_3_r};
      geom4_r.reach <= reach3_r;
      geom4_r.a     <= a3_r;
      geom4_r.dx    <= dx3_r;
      geom4_r.dy    <= dy3_r;
      geom4_r.r     <= r3_r;
      geom4_r.a0    <= a0_3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_geom  = geom4_r;
  assign out_rad   = rad4_r;

endmodule

>>> rtl/core/tlik_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module tlik_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        ce,
  input  logic        in_valid,
  input  logic [59:0] in_rad,
  output logic        out_valid,
  output logic [29:0] out_root
);
  import tlik_pkg::*;

  logic             v_r    [SQRT_STEPS];
  logic [RAD_W-1:0] rem_r  [SQRT_STEPS];
  logic [RT_W-1:0]  root_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam int SH = 2 * (SQRT_STEPS - 1 - k);
    logic             v_in;
    logic [RAD_W-1:0] rem_in;
    logic [RT_W-1:0]  root_in;
    logic [RT_W-1:0]  bitv;
    logic [RT_W-1:0]  trial;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_rad;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign bitv  = RT_W'(1) << SH;
    assign trial = root_in + bitv;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ce) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        if ({2'b00, rem_in} >= trial) begin
          rem_r[k]  <= rem_in - trial[RAD_W-1:0];
          root_r[k] <= (root_in >> 1) + bitv;
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in >> 1;
        end
      end
    end
  end

  assign out_valid = v_r[SQRT_STEPS-1];
  assign out_root  = root_r[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

>>> rtl/core/tlik_cordic.sv
// Pipelined vectoring CORDIC arctangent with rounding to the output angle format.
module tlik_cordic #(
  parameter int ANGLE_FRAC_BITS = tlik_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ce,
  input  logic                in_valid,
  input  logic                in_keep,
  input  logic signed [47:0]  in_y,
  input  logic signed [47:0]  in_x,
  output logic                out_valid,
  output logic signed [15:0]  out_angle
);
  import tlik_pkg::*;

  localparam logic signed [ZW-1:0] RND = $signed(ZW'(64'd1 << (29 - ANGLE_FRAC_BITS)));
  localparam int QSH = 30 - ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] QMAX = 34'sd32767;
  localparam logic signed [ZW-1:0] QMIN = -34'sd32768;

  logic                 pv_r, pkeep_r;
  logic signed [CW-1:0] px_r, py_r;
  logic signed [ZW-1:0] pz_r;

  logic                 v_r    [CORDIC_STEPS];
  logic                 keep_r [CORDIC_STEPS];
  logic signed [CW-1:0] x_r    [CORDIC_STEPS];
  logic signed [CW-1:0] y_r    [CORDIC_STEPS];
  logic signed [ZW-1:0] z_r    [CORDIC_STEPS];

  logic                 ov_r;
  logic signed [15:0]   angle_r;

  logic signed [CW-1:0] xe, ye, px_nxt, py_nxt;
  logic signed [ZW-1:0] pz_nxt, zr, q;
  logic signed [15:0]   angle_nxt;

  assign xe = CW'(in_x);
  assign ye = CW'(in_y);

  always_comb begin
    px_nxt = xe;
    py_nxt = ye;
    pz_nxt = '0;
    if (in_x < 0) begin
      if (in_y >= 0) begin
        pz_nxt = HALF_PI_Q30;
        px_nxt = ye;
        py_nxt = -xe;
      end else begin
        pz_nxt = -HALF_PI_Q30;
        px_nxt = -ye;
        py_nxt = xe;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (ce) begin
      pv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pkeep_r <= in_keep && ((in_x != '0) || (in_y != '0));
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      pz_r    <= pz_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic                 v_in, keep_in;
    logic signed [CW-1:0] x_in, y_in, xs, ys;
    logic signed [ZW-1:0] z_in;

    if (i == 0) begin : g_first
      assign v_in    = pv_r;
      assign keep_in = pkeep_r;
      assign x_in    = px_r;
      assign y_in    = py_r;
      assign z_in    = pz_r;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign keep_in = keep_r[i-1];
      assign x_in    = x_r[i-1];
      assign y_in    = y_r[i-1];
      assign z_in    = z_r[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (ce) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        keep_r[i] <= keep_in;
        if (y_in > 0) begin
          x_r[i] <= x_in + ys;
          y_r[i] <= y_in - xs;
          z_r[i] <= z_in + atan_q30(i);
        end else begin
          x_r[i] <= x_in - ys;
          y_r[i] <= y_in + xs;
          z_r[i] <= z_in - atan_q30(i);
        end
      end
    end
  end

  assign zr = z_r[CORDIC_STEPS-1] + RND;
  assign q  = zr >>> QSH;

  always_comb begin
    if (q > QMAX) begin
      angle_nxt = 16'sh7FFF;
    end else if (q < QMIN) begin
      angle_nxt = -16'sh8000;
    end else begin
      angle_nxt = q[15:0];
    end
    if (!keep_r[CORDIC_STEPS-1]) begin
      angle_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ce) begin
      ov_r <= v_r[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_angle = angle_r;

endmodule
